/* hdl/i2c_master_bit_sequencer_defines.svh */
// Assertion macros shared by the I2C master bit sequencer RTL
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// checked outside reset only
`define I2CMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define I2CMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/i2cms_pkg.sv */
// Types, constants and line sequence functions of the I2C master bit sequencer
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam int unsigned HpW = 16;
  localparam logic [HpW-1:0] HALF_PERIOD_RST = 16'd10;
  localparam logic [6:0] SCAN_ADDR_FIRST = 7'd1;
  localparam logic [6:0] SCAN_ADDR_LAST  = 7'd127;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_ACK   = 3'd4,
    CMD_NACK  = 3'd5,
    CMD_SCAN  = 3'd6
  } cmd_e;

  // segments of a scan: start, address write, stop
  typedef enum logic [1:0] {
    SEG_START = 2'd0,
    SEG_WRITE = 2'd1,
    SEG_STOP  = 2'd2
  } seg_e;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [3:0] phase;
    logic [3:0] bit_idx;
    logic [7:0] shift;
    seg_e       seg;
    logic [6:0] addr;
    logic       nack;
    logic [7:0] rx;
    logic [6:0] found;
  } seq_state_t;

  typedef struct packed {
    seq_state_t     seq;
    cmd_e           op;
    logic           busy;
    logic [HpW-1:0] wait_cnt;
  } core_t;

  typedef struct packed {
    seq_state_t s;
    logic       go;
  } seq_ret_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
    logic [6:0] found_address;
  } res_t;

  localparam core_t CORE_RST = '{
    seq: '{scl: 1'b1, sda: 1'b1, phase: 4'd0, bit_idx: 4'd0, shift: 8'd0,
           seg: SEG_START, addr: SCAN_ADDR_FIRST, nack: 1'b0, rx: 8'd0,
           found: 7'd0},
    op: CMD_START, busy: 1'b0, wait_cnt: '0
  };

  function automatic seq_ret_t seq_start(seq_state_t s);
    seq_ret_t r;
    r.s  = s;
    r.go = 1'b1;
    unique case (s.phase)
      4'd0:    r.s.sda = 1'b1;
      4'd1:    r.s.scl = 1'b1;
      4'd2:    r.s.sda = 1'b0;
      4'd3:    r.s.scl = 1'b0;
      default: r.go = 1'b0;
    endcase
    if (r.go) r.s.phase = s.phase + 4'd1;
    return r;
  endfunction

  function automatic seq_ret_t seq_stop(seq_state_t s);
    seq_ret_t r;
    r.s  = s;
    r.go = 1'b1;
    unique case (s.phase)
      4'd0:    r.s.sda = 1'b0;
      4'd1:    r.s.scl = 1'b1;
      4'd2:    r.s.sda = 1'b1;
      default: r.go = 1'b0;
    endcase
    if (r.go) r.s.phase = s.phase + 4'd1;
    return r;
  endfunction

  function automatic seq_ret_t seq_ack(seq_state_t s);
    seq_ret_t r;
    r.s  = s;
    r.go = 1'b1;
    unique case (s.phase)
      4'd0:    r.s.sda = 1'b0;
      4'd1:    r.s.scl = 1'b1;
      4'd2:    r.s.scl = 1'b0;
      4'd3:    r.s.sda = 1'b1;
      default: r.go = 1'b0;
    endcase
    if (r.go) r.s.phase = s.phase + 4'd1;
    return r;
  endfunction

  function automatic seq_ret_t seq_nack(seq_state_t s);
    seq_ret_t r;
    r.s  = s;
    r.go = 1'b1;
    unique case (s.phase)
      4'd0:    r.s.sda = 1'b1;
      4'd1:    r.s.scl = 1'b1;
      4'd2:    r.s.scl = 1'b0;
      default: r.go = 1'b0;
    endcase
    if (r.go) r.s.phase = s.phase + 4'd1;
    return r;
  endfunction

  function automatic seq_ret_t seq_write(seq_state_t s, logic sda);
    seq_ret_t r;
    r.s  = s;
    r.go = 1'b1;
    if (s.bit_idx < BITS_PER_BYTE) begin
      if (s.phase == 4'd0) begin
        r.s.sda   = s.shift[7];
        r.s.shift = {s.shift[6:0], 1'b0};
        r.s.phase = 4'd1;
      end else if (s.phase == 4'd1) begin
        r.s.scl   = 1'b1;
        r.s.phase = 4'd2;
      end else begin
        r.s.scl     = 1'b0;
        r.s.phase   = 4'd0;
        r.s.bit_idx = s.bit_idx + 4'd1;
      end
    end else begin
      // ack slot: release SDA, clock once, sample on the SCL fall
      unique case (s.phase)
        4'd0: r.s.sda = 1'b1;
        4'd1: r.s.scl = 1'b1;
        4'd2: begin
          r.s.nack = sda;
          r.s.scl  = 1'b0;
        end
        default: r.go = 1'b0;
      endcase
      if (r.go) r.s.phase = s.phase + 4'd1;
    end
    return r;
  endfunction

  function automatic seq_ret_t seq_read(seq_state_t s, logic sda);
    seq_ret_t r;
    r.s  = s;
    r.go = 1'b1;
    if (s.phase == 4'd0) begin
      r.s.sda   = 1'b1;
      r.s.phase = 4'd1;
    end else if (s.phase == 4'd1) begin
      if (s.bit_idx >= BITS_PER_BYTE) begin
        r.s.rx = s.shift;
        r.go   = 1'b0;
      end else begin
        r.s.scl   = 1'b1;
        r.s.phase = 4'd2;
      end
    end else begin
      r.s.shift   = {s.shift[6:0], sda};
      r.s.scl     = 1'b0;
      r.s.bit_idx = s.bit_idx + 4'd1;
      r.s.phase   = 4'd1;
    end
    return r;
  endfunction

  // At most one segment ends per line step, so the chain below is short.
  function automatic seq_ret_t seq_scan(seq_state_t s, logic sda);
    seq_ret_t   a;
    seq_state_t t;
    t = s;
    if (t.seg == SEG_START) begin
      a = seq_start(t);
      if (a.go) return a;
      t         = a.s;
      t.seg     = SEG_WRITE;
      t.phase   = 4'd0;
      t.bit_idx = 4'd0;
      t.shift   = {t.addr, 1'b0};
    end
    if (t.seg == SEG_WRITE) begin
      a = seq_write(t, sda);
      if (a.go) return a;
      t       = a.s;
      t.seg   = SEG_STOP;
      t.phase = 4'd0;
    end
    a = seq_stop(t);
    if (a.go) return a;
    t = a.s;
    if (!t.nack) begin
      t.found = t.addr;
      a.s     = t;
      a.go    = 1'b0;
      return a;
    end
    if (t.addr >= SCAN_ADDR_LAST) begin
      t.found = 7'd0;
      a.s     = t;
      a.go    = 1'b0;
      return a;
    end
    t.addr  = t.addr + 7'd1;
    t.seg   = SEG_START;
    t.phase = 4'd0;
    return seq_start(t);
  endfunction

  function automatic seq_ret_t run_action(cmd_e op, seq_state_t s, logic sda);
    seq_ret_t r;
    r.s  = s;
    r.go = 1'b0;
    unique case (op)
      CMD_START: r = seq_start(s);
      CMD_STOP:  r = seq_stop(s);
      CMD_WRITE: r = seq_write(s, sda);
      CMD_READ:  r = seq_read(s, sda);
      CMD_ACK:   r = seq_ack(s);
      CMD_NACK:  r = seq_nack(s);
      CMD_SCAN:  r = seq_scan(s, sda);
      default:   r.go = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/i2cms_cmd_if.sv */
// Command channel: one word per clock tick of bus time
`timescale 1ns / 1ps

interface i2cms_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, cmd_valid, command, tx_byte, sda_in, input ready);
  modport sink   (input valid, cmd_valid, command, tx_byte, sda_in, output ready);
endinterface

/* hdl/i2cms_res_if.sv */
// Result channel: line drives and status, one word per accepted command word
`timescale 1ns / 1ps

interface i2cms_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       nack;
  logic [6:0] found_address;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, nack,
                  found_address, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, nack,
                  found_address, output ready);
endinterface

/* hdl/i2cms_cfg_if.sv */
// Configuration write channel carrying the half period
`timescale 1ns / 1ps

interface i2cms_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [i2cms_pkg::HpW-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hdl/i2c_master_bit_sequencer.sv */
// Top level of the I2C master bit sequencer
//
//   channel  dir  handshake     carries
//   cmd_i    in   valid/ready   cmd_valid, command, tx_byte, sda_in
//   res_o    out  valid/ready   scl_out, sda_out, busy_res, done_res, rx_byte, nack,
//                               found_address
//   cfg_i    in   valid/ready   half_period (always ready)
//
// One command word is taken each cycle unless stalled; its result is registered and
// shows the cycle after. The step logic is a single pass of one line change from the
// state regs. cmd_i.ready drops only while a result word sits unread and res_o.ready
// is low. Reset releases both lines, clears the state and sets half_period to 10.
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_defines.svh"

module i2c_master_bit_sequencer (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cms_cmd_if.sink    cmd_i,
  i2cms_res_if.source  res_o,
  i2cms_cfg_if.sink    cfg_i
);

  i2cms_pkg::core_t           core_q, core_d;
  logic [i2cms_pkg::HpW-1:0]  half_period_q;
  i2cms_pkg::item_t           item;
  i2cms_pkg::res_t            res_d;
  logic                       room;
  logic                       accept;

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = room;
  assign accept      = cmd_i.valid && room;

  assign item.cmd_valid = cmd_i.cmd_valid;
  assign item.command   = cmd_i.command;
  assign item.tx_byte   = cmd_i.tx_byte;
  assign item.sda_in    = cmd_i.sda_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= i2cms_pkg::HALF_PERIOD_RST;
    end else if (cfg_i.valid) begin
      half_period_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_q <= i2cms_pkg::CORE_RST;
    end else if (accept) begin
      core_q <= core_d;
    end
  end

  i2cms_step u_step (
    .core_i        (core_q),
    .item_i        (item),
    .half_period_i (half_period_q),
    .core_o        (core_d),
    .res_o         (res_d)
  );

  i2cms_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .res_i  (res_d),
    .room_o (room),
    .res_o  (res_o)
  );

  // a running sequence always has a hold in progress
  `I2CMS_ASSERT_ALWAYS(a_busy_wait, core_q.busy |-> (core_q.wait_cnt != '0), "busy with empty hold")
  // the tick that reports done leaves the block idle
  `I2CMS_ASSERT(a_done_idle, (accept && res_d.done_res) |=> !core_q.busy, "done but still busy")
  // every accepted word produces a result word next cycle
  `I2CMS_ASSERT(a_acc_res, accept |=> res_o.valid, "accepted word without result")
  // busy reported to the output matches the state that was stored
  `I2CMS_ASSERT(a_busy_out, accept |=> (res_o.busy_res == core_q.busy), "busy flag mismatch")

endmodule

/* hdl/i2cms_step.sv */
// Next-state logic for one tick: hold countdown and one line step
`timescale 1ns / 1ps

module i2cms_step (
  input  i2cms_pkg::core_t            core_i,
  input  i2cms_pkg::item_t            item_i,
  input  logic [i2cms_pkg::HpW-1:0]   half_period_i,
  output i2cms_pkg::core_t            core_o,
  output i2cms_pkg::res_t             res_o
);

  logic [i2cms_pkg::HpW-1:0] hold;
  logic [i2cms_pkg::HpW-1:0] wait_dec;
  i2cms_pkg::seq_state_t     fresh;
  i2cms_pkg::seq_ret_t       act;
  i2cms_pkg::cmd_e           cmd;
  logic                      done;

  // a zero half period is treated as a half period of one
  assign hold     = (half_period_i == '0) ? {{(i2cms_pkg::HpW-1){1'b0}}, 1'b1}
                                          : half_period_i;
  assign wait_dec = (core_i.wait_cnt != '0) ? core_i.wait_cnt - 1'b1 : '0;
  assign cmd      = i2cms_pkg::cmd_e'(item_i.command);

  always_comb begin
    fresh         = core_i.seq;
    fresh.phase   = 4'd0;
    fresh.bit_idx = 4'd0;
    fresh.shift   = (cmd == i2cms_pkg::CMD_WRITE) ? item_i.tx_byte : 8'd0;
    fresh.addr    = i2cms_pkg::SCAN_ADDR_FIRST;
    fresh.seg     = i2cms_pkg::SEG_START;
  end

  always_comb begin
    core_o = core_i;
    done   = 1'b0;
    act    = i2cms_pkg::run_action(core_i.op, core_i.seq, item_i.sda_in);
    if (core_i.busy) begin
      core_o.wait_cnt = wait_dec;
      if (wait_dec == '0) begin
        core_o.seq = act.s;
        if (act.go) begin
          core_o.wait_cnt = hold;
        end else begin
          core_o.busy = 1'b0;
          done        = 1'b1;
        end
      end
    end else if (item_i.cmd_valid && (item_i.command <= i2cms_pkg::CMD_SCAN)) begin
      act             = i2cms_pkg::run_action(cmd, fresh, item_i.sda_in);
      core_o.op       = cmd;
      core_o.busy     = 1'b1;
      core_o.seq      = act.s;
      core_o.wait_cnt = hold;
    end
  end

  always_comb begin
    res_o.scl_out       = core_o.seq.scl;
    res_o.sda_out       = core_o.seq.sda;
    res_o.busy_res      = core_o.busy;
    res_o.done_res      = done;
    res_o.rx_byte       = core_o.seq.rx;
    res_o.nack          = core_o.seq.nack;
    res_o.found_address = core_o.seq.found;
  end

endmodule

/* hdl/i2cms_out_stage.sv */
// Result register between the step logic and the result channel
`timescale 1ns / 1ps

module i2cms_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  i2cms_pkg::res_t   res_i,
  output logic              room_o,
  i2cms_res_if.source       res_o
);

  logic            valid_q, valid_d;
  i2cms_pkg::res_t data_q;

  // a new word may enter in the same cycle the held one leaves
  assign room_o  = !valid_q || res_o.ready;
  assign valid_d = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.scl_out       = data_q.scl_out;
  assign res_o.sda_out       = data_q.sda_out;
  assign res_o.busy_res      = data_q.busy_res;
  assign res_o.done_res      = data_q.done_res;
  assign res_o.rx_byte       = data_q.rx_byte;
  assign res_o.nack          = data_q.nack;
  assign res_o.found_address = data_q.found_address;

endmodule

/* tb/tb.sv */
// Self-checking bench for the I2C master bit sequencer: directed plan, random sweep, line predictor
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 8;
  localparam int SWEEP_WORDS     = 200;
  localparam int NO_PIN          = -1;

  // code outside the command set, must be ignored
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // line moves: bit 1 picks the line (1 SCL, 0 SDA), bit 0 is the level
  localparam logic [1:0] MV_SDA_LO = 2'b00;
  localparam logic [1:0] MV_SDA_HI = 2'b01;
  localparam logic [1:0] MV_SCL_LO = 2'b10;
  localparam logic [1:0] MV_SCL_HI = 2'b11;

  // first move in the low bits; top slot of the 3-move programs is never reached
  localparam logic [7:0] START_MOVES   = {MV_SCL_LO, MV_SDA_LO, MV_SCL_HI, MV_SDA_HI};
  localparam logic [7:0] STOP_MOVES    = {MV_SDA_LO, MV_SDA_HI, MV_SCL_HI, MV_SDA_LO};
  localparam logic [7:0] ACK_MOVES     = {MV_SDA_HI, MV_SCL_LO, MV_SCL_HI, MV_SDA_LO};
  localparam logic [7:0] RELEASE_MOVES = {MV_SDA_LO, MV_SCL_LO, MV_SCL_HI, MV_SDA_HI};

  localparam logic [15:0] SWEEP_PERIODS [6] = '{16'd1, 16'd2, 16'd1, 16'd4, 16'd7, 16'd2};

  typedef enum logic [1:0] {ROW_IDLE, ROW_CMD, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RAND, SDA_MOSTLY_HIGH} sda_mode_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [2:0] cmd;
    logic [7:0] tx;
    sda_mode_e  sda;
    logic       noise;   // offer commands while busy
    logic       steady;  // no idling on either side
    logic [15:0] period;
    int         pin_rx;
    int         pin_nack;
    int         pin_found;
  } row_t;

  // kind, cmd, tx, sda, noise, steady, period, rx, nack, found (pins on the closing word)
  localparam row_t PLAN [24] = '{
    '{ROW_IDLE, i2cms_pkg::CMD_START, 8'h00, SDA_RAND, 1'b0, 1'b0, 16'd0, 0, 0, 0},
    '{ROW_CMD,  i2cms_pkg::CMD_START, 8'h00, SDA_RAND, 1'b0, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CFG,  i2cms_pkg::CMD_START, 8'h00, SDA_RAND, 1'b0, 1'b0, 16'd1,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_WRITE, 8'hFF, SDA_HIGH, 1'b0, 1'b0, 16'd0, NO_PIN, 1, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_WRITE, 8'h00, SDA_LOW,  1'b0, 1'b0, 16'd0, NO_PIN, 0, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_READ,  8'h00, SDA_HIGH, 1'b0, 1'b0, 16'd0, 255, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_READ,  8'h00, SDA_LOW,  1'b0, 1'b0, 16'd0, 0, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_ACK,   8'h00, SDA_RAND, 1'b0, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_NACK,  8'h00, SDA_RAND, 1'b0, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_STOP,  8'h00, SDA_RAND, 1'b0, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  CMD_UNUSED,           8'h5A, SDA_RAND, 1'b0, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_WRITE, 8'hA5, SDA_RAND, 1'b1, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_READ,  8'h00, SDA_RAND, 1'b1, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_SCAN,  8'h00, SDA_LOW,  1'b0, 1'b0, 16'd0, NO_PIN, 0, 1},
    '{ROW_CMD,  i2cms_pkg::CMD_SCAN,  8'h00, SDA_HIGH, 1'b0, 1'b0, 16'd0, NO_PIN, 1, 0},
    '{ROW_CFG,  i2cms_pkg::CMD_START, 8'h00, SDA_RAND, 1'b0, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_WRITE, 8'h3C, SDA_RAND, 1'b1, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_SCAN,  8'h00, SDA_MOSTLY_HIGH, 1'b0, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CFG,  i2cms_pkg::CMD_START, 8'h00, SDA_RAND, 1'b0, 1'b0, 16'd2,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_STOP,  8'h00, SDA_RAND, 1'b0, 1'b1, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CFG,  i2cms_pkg::CMD_START, 8'h00, SDA_RAND, 1'b0, 1'b0, 16'd3,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_READ,  8'h00, SDA_RAND, 1'b1, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_ACK,   8'h00, SDA_RAND, 1'b0, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN},
    '{ROW_CMD,  i2cms_pkg::CMD_START, 8'h00, SDA_RAND, 1'b0, 1'b0, 16'd0,
      NO_PIN, NO_PIN, NO_PIN}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  i2cms_cmd_if cmd_bus ();
  i2cms_res_if res_bus ();
  i2cms_cfg_if cfg_bus ();

  i2c_master_bit_sequencer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predicted sequencer state
  logic [15:0]     period_reg = i2cms_pkg::HALF_PERIOD_RST;
  logic            scl_q      = 1'b1;
  logic            sda_q      = 1'b1;
  logic            busy_q     = 1'b0;
  i2cms_pkg::cmd_e op_q       = i2cms_pkg::CMD_START;
  logic [3:0]      phase_q    = 4'd0;
  logic [3:0]      bit_q      = 4'd0;
  logic [7:0]      shift_q    = 8'd0;
  logic [15:0]     hold_q     = 16'd0;
  logic [6:0]      addr_q     = i2cms_pkg::SCAN_ADDR_FIRST;
  i2cms_pkg::seg_e seg_q      = i2cms_pkg::SEG_START;
  logic [7:0]      rx_q       = 8'd0;
  logic            nack_q     = 1'b0;
  logic [6:0]      found_q    = 7'd0;

  i2cms_pkg::res_t line_words_due [$];
  int   mismatches   = 0;
  int   words_sent   = 0;
  logic hold_off_req = 1'b0;
  logic no_idle      = 1'b0;

  function automatic logic play_seq(logic [7:0] moves, int unsigned len);
    logic [1:0] mv;
    if (phase_q >= len) return 1'b0;
    mv = moves[2*phase_q +: 2];
    if (mv[1]) scl_q = mv[0];
    else sda_q = mv[0];
    phase_q = phase_q + 4'd1;
    return 1'b1;
  endfunction

  function automatic logic step_write(logic sda);
    if (bit_q < i2cms_pkg::BITS_PER_BYTE) begin
      case (phase_q)
        4'd0: begin
          sda_q   = shift_q[7];
          shift_q = {shift_q[6:0], 1'b0};
          phase_q = 4'd1;
        end
        4'd1: begin
          scl_q   = 1'b1;
          phase_q = 4'd2;
        end
        default: begin
          scl_q   = 1'b0;
          phase_q = 4'd0;
          bit_q   = bit_q + 4'd1;
        end
      endcase
      return 1'b1;
    end
    // ack slot: sampled with the SCL fall
    if (phase_q == 4'd2) nack_q = sda;
    return play_seq(RELEASE_MOVES, 3);
  endfunction

  function automatic logic step_read(logic sda);
    if (phase_q == 4'd0) begin
      sda_q   = 1'b1;
      phase_q = 4'd1;
      return 1'b1;
    end
    if (phase_q == 4'd1) begin
      if (bit_q >= i2cms_pkg::BITS_PER_BYTE) begin
        rx_q = shift_q;
        return 1'b0;
      end
      scl_q   = 1'b1;
      phase_q = 4'd2;
      return 1'b1;
    end
    shift_q = {shift_q[6:0], sda};
    scl_q   = 1'b0;
    bit_q   = bit_q + 4'd1;
    phase_q = 4'd1;
    return 1'b1;
  endfunction

  function automatic logic step_scan(logic sda);
    if (seg_q == i2cms_pkg::SEG_START) begin
      if (play_seq(START_MOVES, 4)) return 1'b1;
      seg_q   = i2cms_pkg::SEG_WRITE;
      phase_q = 4'd0;
      bit_q   = 4'd0;
      shift_q = {addr_q, 1'b0};
    end
    if (seg_q == i2cms_pkg::SEG_WRITE) begin
      if (step_write(sda)) return 1'b1;
      seg_q   = i2cms_pkg::SEG_STOP;
      phase_q = 4'd0;
    end
    if (play_seq(STOP_MOVES, 3)) return 1'b1;
    if (!nack_q) begin
      found_q = addr_q;
      return 1'b0;
    end
    if (addr_q >= i2cms_pkg::SCAN_ADDR_LAST) begin
      found_q = 7'd0;
      return 1'b0;
    end
    // next address starts on this same tick
    addr_q  = addr_q + 7'd1;
    seg_q   = i2cms_pkg::SEG_START;
    phase_q = 4'd0;
    return play_seq(START_MOVES, 4);
  endfunction

  function automatic logic run_op(logic sda);
    case (op_q)
      i2cms_pkg::CMD_START: return play_seq(START_MOVES, 4);
      i2cms_pkg::CMD_STOP:  return play_seq(STOP_MOVES, 3);
      i2cms_pkg::CMD_WRITE: return step_write(sda);
      i2cms_pkg::CMD_READ:  return step_read(sda);
      i2cms_pkg::CMD_ACK:   return play_seq(ACK_MOVES, 4);
      i2cms_pkg::CMD_NACK:  return play_seq(RELEASE_MOVES, 3);
      i2cms_pkg::CMD_SCAN:  return step_scan(sda);
      default:              return 1'b0;
    endcase
  endfunction

  // one bus tick of the sequencer
  function automatic i2cms_pkg::res_t bus_tick(i2cms_pkg::item_t w);
    i2cms_pkg::res_t r;
    logic [15:0]     reload;
    reload     = (period_reg == 16'd0) ? 16'd1 : period_reg;
    r.done_res = 1'b0;
    if (busy_q) begin
      if (hold_q != 16'd0) hold_q = hold_q - 16'd1;
      if (hold_q == 16'd0) begin
        if (run_op(w.sda_in)) hold_q = reload;
        else begin
          busy_q     = 1'b0;
          r.done_res = 1'b1;
        end
      end
    end else if (w.cmd_valid && w.command <= i2cms_pkg::CMD_SCAN) begin
      op_q    = i2cms_pkg::cmd_e'(w.command);
      busy_q  = 1'b1;
      phase_q = 4'd0;
      bit_q   = 4'd0;
      shift_q = (w.command == i2cms_pkg::CMD_WRITE) ? w.tx_byte : 8'd0;
      addr_q  = i2cms_pkg::SCAN_ADDR_FIRST;
      seg_q   = i2cms_pkg::SEG_START;
      void'(run_op(w.sda_in));
      hold_q  = reload;
    end
    r.scl_out       = scl_q;
    r.sda_out       = sda_q;
    r.busy_res      = busy_q;
    r.rx_byte       = rx_q;
    r.nack          = nack_q;
    r.found_address = found_q;
    return r;
  endfunction

  function automatic logic pick_sda(sda_mode_e m);
    case (m)
      SDA_LOW:         return 1'b0;
      SDA_HIGH:        return 1'b1;
      SDA_MOSTLY_HIGH: return $urandom_range(0, 3) != 0;
      default:         return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic int sender_gap(logic steady);
    return (steady || no_idle) ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic void field_diff(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // offer one word; pins override the closing (not busy) word
  task automatic push_word(i2cms_pkg::item_t w, int gap, int pin_rx, int pin_nack,
                           int pin_found);
    i2cms_pkg::res_t r;
    if (gap > 0) begin
      cmd_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_bus.valid     = 1'b1;
    cmd_bus.cmd_valid = w.cmd_valid;
    cmd_bus.command   = w.command;
    cmd_bus.tx_byte   = w.tx_byte;
    cmd_bus.sda_in    = w.sda_in;
    do @(posedge clk_i); while (!cmd_bus.ready);
    r = bus_tick(w);
    if (!r.busy_res) begin
      if (pin_rx >= 0) r.rx_byte = pin_rx[7:0];
      if (pin_nack >= 0) r.nack = pin_nack[0];
      if (pin_found >= 0) r.found_address = pin_found[6:0];
    end
    line_words_due.push_back(r);
    words_sent++;
    @(negedge clk_i);
    cmd_bus.valid = 1'b0;
  endtask

  // one command word, then bus ticks until the command closes
  task automatic run_command(i2cms_pkg::item_t first, sda_mode_e mode, logic noise,
                             logic steady, int pin_rx, int pin_nack, int pin_found);
    i2cms_pkg::item_t w;
    w        = first;
    w.sda_in = pick_sda(mode);
    push_word(w, sender_gap(steady), pin_rx, pin_nack, pin_found);
    while (busy_q) begin
      w.cmd_valid = noise ? 1'($urandom_range(0, 1)) : 1'b0;
      w.command   = 3'($urandom_range(0, 7));
      w.tx_byte   = 8'($urandom_range(0, 255));
      w.sda_in    = pick_sda(mode);
      push_word(w, sender_gap(steady), pin_rx, pin_nack, pin_found);
    end
  endtask

  task automatic set_half_period(logic [15:0] value);
    while (line_words_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.data  = value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    period_reg = value;
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  initial begin : result_side
    i2cms_pkg::res_t got;
    i2cms_pkg::res_t want;
    logic fire;
    logic burst;
    logic held_off;
    int   stall;
    res_bus.ready = 1'b0;
    burst    = 1'b0;
    held_off = 1'b0;
    stall    = 0;
    forever begin
      @(posedge clk_i);
      fire = rst_ni && res_bus.valid && res_bus.ready;
      got  = {res_bus.scl_out, res_bus.sda_out, res_bus.busy_res, res_bus.done_res,
              res_bus.rx_byte, res_bus.nack, res_bus.found_address};
      @(negedge clk_i);
      if (fire) begin
        if (line_words_due.size() == 0) begin
          $display("%0t: result word with nothing expected, got %h", $time, got);
          mismatches++;
        end else begin
          want = line_words_due.pop_front();
          field_diff("scl_out", 8'(want.scl_out), 8'(got.scl_out));
          field_diff("sda_out", 8'(want.sda_out), 8'(got.sda_out));
          field_diff("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          field_diff("done_res", 8'(want.done_res), 8'(got.done_res));
          field_diff("rx_byte", want.rx_byte, got.rx_byte);
          field_diff("nack", 8'(want.nack), 8'(got.nack));
          field_diff("found_address", 8'(want.found_address), 8'(got.found_address));
        end
        if ($urandom_range(0, 63) == 0) burst = !burst;
        stall = (no_idle || burst) ? 0 : $urandom_range(0, 17);
      end
      if (hold_off_req && !held_off) begin
        held_off = 1'b1;
        stall    = HOLD_OFF_CYCLES;
      end
      if (stall > 0) begin
        res_bus.ready = 1'b0;
        stall--;
      end else res_bus.ready = 1'b1;
    end
  end

  initial begin : watchdog
    int dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) dead_cycles = 0;
      else dead_cycles++;
    end
    $display("i2c_master_bit_sequencer regression: fail");
    $finish;
  end

  initial begin : stimulus
    row_t             row;
    i2cms_pkg::item_t w;
    int               start_count;
    int               pick;
    logic             steady;
    cmd_bus.valid     = 1'b0;
    cmd_bus.cmd_valid = 1'b0;
    cmd_bus.command   = 3'd0;
    cmd_bus.tx_byte   = 8'd0;
    cmd_bus.sda_in    = 1'b1;
    cfg_bus.valid     = 1'b0;
    cfg_bus.data      = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < $size(PLAN); i++) begin
      row = PLAN[i];
      if (row.kind == ROW_CFG) set_half_period(row.period);
      else begin
        no_idle     = row.steady;
        w.cmd_valid = (row.kind == ROW_CMD);
        w.command   = row.cmd;
        w.tx_byte   = row.tx;
        w.sda_in    = 1'b1;
        run_command(w, row.sda, row.noise, row.steady, row.pin_rx, row.pin_nack,
                    row.pin_found);
        no_idle = 1'b0;
      end
    end

    for (int ph = 0; ph < $size(SWEEP_PERIODS); ph++) begin
      if (ph == $size(SWEEP_PERIODS) - 1) set_half_period(16'($urandom_range(1, 5)));
      else set_half_period(SWEEP_PERIODS[ph]);
      // long receiver hold-off: the block fills and backs up the command side
      if (ph == 2) hold_off_req = 1'b1;
      start_count = words_sent;
      while (words_sent - start_count < SWEEP_WORDS) begin
        steady    = $urandom_range(0, 3) == 0;
        pick      = $urandom_range(0, 15);
        w.tx_byte = 8'($urandom_range(0, 255));
        w.sda_in  = 1'b1;
        if (pick == 0) begin
          w.cmd_valid = 1'b0;
          w.command   = 3'($urandom_range(0, 7));
          repeat ($urandom_range(1, 3))
            run_command(w, SDA_RAND, 1'b0, steady, NO_PIN, NO_PIN, NO_PIN);
        end else if (pick == 1) begin
          w.cmd_valid = 1'b1;
          w.command   = CMD_UNUSED;
          run_command(w, SDA_RAND, 1'b0, steady, NO_PIN, NO_PIN, NO_PIN);
        end else begin
          w.cmd_valid = 1'b1;
          w.command   = 3'($urandom_range(0, 6));
          run_command(w, (w.command == i2cms_pkg::CMD_SCAN) ? SDA_MOSTLY_HIGH : SDA_RAND,
                      1'($urandom_range(0, 1)), steady, NO_PIN, NO_PIN, NO_PIN);
        end
      end
    end

    while (line_words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("i2c_master_bit_sequencer regression: pass");
    else $display("i2c_master_bit_sequencer regression: fail");
    $finish;
  end

endmodule
